// ----- src/dsot_pkg.sv -----
// dsot_pkg: shared types and constants for the diagonal snake order table
// holds the controller state enum, the command/status structs and field widths
// no dependencies
package dsot_pkg;

   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_MAX_ROWS    = 64;

   localparam int CFG_W   = 7;   // grid size register width
   localparam int CSR_IDX_W = 2;
   localparam int COORD_W = 6;   // square_x / square_y
   localparam int ENTRY_W = 11;  // stored step
   localparam int STEP_W  = 13;  // step counter, holds half of 127*127
   localparam int PROD_W  = 14;  // columns * rows
   localparam int WALK_W  = 9;   // signed walk coordinate
   localparam int VALUE_W = 13;

   localparam logic [CFG_W-1:0] RESET_COLUMNS = 7'd8;
   localparam logic [CFG_W-1:0] RESET_ROWS    = 7'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLUMNS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_ROWS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_ORDER = 2'd3;

   localparam logic OP_BUILD  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_WALK_A,
      ST_WALK_B,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic prep;
      logic walk_a;
      logic walk_b;
      logic finish_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_lookup;
      logic walk_done;
      logic out_free;
   } status_type;

endpackage

// ----- src/diagonal_snake_order_table_core.sv -----
// diagonal_snake_order_table_core: top level of the diagonal snake order table
// ties dsot_ctrl and dsot_datapath together, uses dsot_pkg
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser: operation; tdata: square_x, square_y
//   rsp      out        rsp_tvalid/rsp_tready  tdata: value
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// a lookup passes through prep, table read and result before the next acceptance
// a build uses one table write port, two writes per step (square and its point mirror)
// after reset the table is swept to zero, every address in turn, no item taken meanwhile
// the result register frees the core to take the next item while rsp is stalled
// csr writes are always taken, reset is synchronous and active high
module diagonal_snake_order_table_core
   import dsot_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [5:0] square_x, [11:6] square_y, [15:12] zero
   input  logic                 req_tuser,   // [0] operation
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [12:0] value, [15:13] zero
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   cmd_type            cmd;
   status_type         status;
   logic [VALUE_W-1:0] rsp_value;

   dsot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   dsot_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_op    (req_tuser),
      .req_x     (req_tdata[COORD_W-1:0]),
      .req_y     (req_tdata[2*COORD_W-1:COORD_W]),
      .csr_wr    (csr_valid),
      .csr_idx   (csr_index),
      .csr_wdata (csr_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'b000, rsp_value};

endmodule

// ----- src/dsot_table_mem.sv -----
// dsot_table_mem: single write port, single registered read port table store
// used by dsot_datapath; no package dependency
module dsot_table_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dsot_datapath.sv -----
// dsot_datapath: configuration registers, diagonal walk, address arithmetic,
// table store and result register; driven by dsot_ctrl commands, uses dsot_pkg
module dsot_datapath
   import dsot_pkg::*;
#(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_op,
   input  logic [COORD_W-1:0]   req_x,
   input  logic [COORD_W-1:0]   req_y,
   input  logic                 csr_wr,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VALUE_W-1:0]   rsp_value
);

   localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
   localparam int AW     = $clog2(DEPTH);
   localparam int FULL_W = (AW > PROD_W) ? AW : PROD_W;

   // configuration
   logic [CFG_W-1:0] cfg_cols_ff, cfg_rows_ff;
   logic             cfg_flip_ff, cfg_rev_ff;

   // captured item
   logic               op_ff;
   logic [COORD_W-1:0] x_ff, y_ff;

   // per-item working registers
   logic [CFG_W-1:0]  cols_ff, rows_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [AW-1:0]     addr_ff;
   logic              lk_in_ff;
   logic              vis_in_ff;
   logic [STEP_W-1:0] step_ff;
   logic signed [WALK_W-1:0] i_ff, j_ff, i_in, j_in;
   logic              dir_ff, dir_in;   // 0: x+1 y-1, 1: x-1 y+1
   logic [AW-1:0]     clr_cnt_ff;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic [CFG_W-1:0]  cols_eff_c, rows_eff_c;
   logic [PROD_W-1:0] prod_c;
   logic signed [WALK_W-1:0] ys_c, cols_s, rows_s, rows_eff_s;
   logic              lk_in_c, in_grid_c;
   logic [CFG_W-1:0]  mul_x_c, mul_y_c, mul_rows_c;
   logic [PROD_W-1:0] mul_c;
   logic [FULL_W-1:0] addr_full_c, mir_full_c;
   logic [STEP_W-1:0] half_c;
   logic [VALUE_W-1:0] value_c;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data, mem_rd_data;

   // grid size saturated to 1..max
   always_comb begin
      if (cfg_cols_ff == '0) begin
         cols_eff_c = CFG_W'(1);
      end else if ({2'b00, cfg_cols_ff} > 9'(MAX_COLUMNS)) begin
         cols_eff_c = CFG_W'(MAX_COLUMNS);
      end else begin
         cols_eff_c = cfg_cols_ff;
      end
      if (cfg_rows_ff == '0) begin
         rows_eff_c = CFG_W'(1);
      end else if ({2'b00, cfg_rows_ff} > 9'(MAX_ROWS)) begin
         rows_eff_c = CFG_W'(MAX_ROWS);
      end else begin
         rows_eff_c = cfg_rows_ff;
      end
   end

   assign prod_c     = cols_eff_c * rows_eff_c;
   assign rows_eff_s = $signed({2'b00, rows_eff_c});
   assign cols_s     = $signed({2'b00, cols_ff});
   assign rows_s     = $signed({2'b00, rows_ff});

   // lookup row, optionally mirrored
   assign ys_c = cfg_flip_ff ? (rows_eff_s - $signed({3'b000, y_ff}) - WALK_W'(1))
                             : $signed({3'b000, y_ff});
   assign lk_in_c = ({1'b0, x_ff} < cols_eff_c) && !ys_c[WALK_W-1] && (ys_c < rows_eff_s);

   assign in_grid_c = !i_ff[WALK_W-1] && !j_ff[WALK_W-1] && (i_ff < cols_s) && (j_ff < rows_s);

   // shared address multiplier: lookup square during prep, walk square otherwise
   always_comb begin
      if (cmd.prep) begin
         mul_x_c    = {1'b0, x_ff};
         mul_y_c    = ys_c[CFG_W-1:0];
         mul_rows_c = rows_eff_c;
      end else begin
         mul_x_c    = i_ff[CFG_W-1:0];
         mul_y_c    = j_ff[CFG_W-1:0];
         mul_rows_c = rows_ff;
      end
   end

   assign mul_c       = mul_x_c * mul_rows_c;
   assign addr_full_c = FULL_W'(mul_c) + FULL_W'(mul_y_c);
   // point mirror of x*rows+y is cols*rows-1 minus that address
   assign mir_full_c  = FULL_W'(prod_ff) - FULL_W'(1) - FULL_W'(addr_ff);

   // walk step with edge bounce
   always_comb begin
      logic signed [WALK_W-1:0] ni, nj;
      ni     = dir_ff ? (i_ff - WALK_W'(1)) : (i_ff + WALK_W'(1));
      nj     = dir_ff ? (j_ff + WALK_W'(1)) : (j_ff - WALK_W'(1));
      dir_in = dir_ff;
      if (ni[WALK_W-1] || nj[WALK_W-1] || (ni >= cols_s) || (nj >= rows_s)) begin
         if (ni >= cols_s) begin
            ni = cols_s - WALK_W'(1);
            nj = nj + WALK_W'(2);
         end
         if (nj >= rows_s) begin
            nj = rows_s - WALK_W'(1);
            ni = ni + WALK_W'(2);
         end
         if (ni[WALK_W-1]) begin
            ni = '0;
         end
         if (nj[WALK_W-1]) begin
            nj = '0;
         end
         dir_in = !dir_ff;
      end
      i_in = ni;
      j_in = nj;
   end

   // result value
   assign half_c = prod_ff[PROD_W-1:1];
   always_comb begin
      if (op_ff == OP_BUILD) begin
         value_c = prod_ff[VALUE_W-1:0];
      end else if (!lk_in_ff) begin
         value_c = '0;
      end else if (cfg_rev_ff) begin
         value_c = VALUE_W'(mem_rd_data);
      end else if (STEP_W'(mem_rd_data) >= half_c) begin
         value_c = '0;  // countdown saturates
      end else begin
         value_c = half_c - STEP_W'(mem_rd_data) - STEP_W'(1);
      end
   end

   // table write port
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_cnt_ff;
      mem_wr_data = '0;
      if (cmd.clear_wr) begin
         mem_wr_en = 1'b1;
      end else if (cmd.walk_a) begin
         mem_wr_en   = in_grid_c;
         mem_wr_addr = addr_full_c[AW-1:0];
         mem_wr_data = step_ff[ENTRY_W-1:0];
      end else if (cmd.walk_b) begin
         mem_wr_en   = vis_in_ff;
         mem_wr_addr = mir_full_c[AW-1:0];
         mem_wr_data = step_ff[ENTRY_W-1:0];
      end
   end

   dsot_table_mem #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff  <= RESET_COLUMNS;
         cfg_rows_ff  <= RESET_ROWS;
         cfg_flip_ff  <= 1'b0;
         cfg_rev_ff   <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               CSR_NUM_COLUMNS:   cfg_cols_ff <= csr_wdata;
               CSR_NUM_ROWS:      cfg_rows_ff <= csr_wdata;
               CSR_FLIP_ROWS:     cfg_flip_ff <= csr_wdata[0];
               CSR_REVERSE_ORDER: cfg_rev_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         x_ff  <= req_x;
         y_ff  <= req_y;
      end
      if (cmd.prep) begin
         cols_ff  <= cols_eff_c;
         rows_ff  <= rows_eff_c;
         prod_ff  <= prod_c;
         addr_ff  <= addr_full_c[AW-1:0];
         lk_in_ff <= lk_in_c;
         step_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         dir_ff   <= 1'b0;
      end
      if (cmd.walk_a) begin
         addr_ff   <= addr_full_c[AW-1:0];
         vis_in_ff <= in_grid_c;
      end
      if (cmd.walk_b) begin
         i_ff    <= i_in;
         j_ff    <= j_in;
         dir_ff  <= dir_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.finish_load) begin
         rsp_value_ff <= value_c;
      end
   end

   assign status.clear_last = (clr_cnt_ff == AW'(DEPTH - 1));
   assign status.is_lookup  = (op_ff == OP_LOOKUP);
   assign status.walk_done  = (step_ff >= half_c);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ----- src/dsot_ctrl.sv -----
// dsot_ctrl: sequencer for table clearing, build walk and lookup
// issues cmd_type commands to dsot_datapath, uses dsot_pkg
module dsot_ctrl
   import dsot_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.is_lookup ? ST_READ : ST_WALK_A;
         end
         ST_WALK_A: begin
            state_in = status.walk_done ? ST_FINISH : ST_WALK_B;
         end
         ST_WALK_B: state_in = ST_WALK_A;
         ST_READ:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_PREP:   cmd.prep = 1'b1;
         ST_WALK_A: cmd.walk_a = !status.walk_done;
         ST_WALK_B: cmd.walk_b = 1'b1;
         ST_READ:   ;
         ST_FINISH: cmd.finish_load = status.out_free;
         default:   ;
      endcase
   end

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for diagonal_snake_order_table_core
// drives builds and lookups over the req stream, checks rsp against an in-bench scan order model
// depends on dsot_pkg and diagonal_snake_order_table_core
module tb;
   import dsot_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_ITEMS = 500;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TABLE_SIZE  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

   class scan_order_scoreboard;
      logic [ENTRY_W-1:0] step_table [TABLE_SIZE];
      logic [CFG_W-1:0]   columns_reg;
      logic [CFG_W-1:0]   rows_reg;
      logic               flip_reg;
      logic               reverse_reg;
      logic [VALUE_W-1:0] expected_orders [$];
      int                 errors;

      function new();
         foreach (step_table[k]) step_table[k] = '0;
         columns_reg = RESET_COLUMNS;
         rows_reg    = RESET_ROWS;
         flip_reg    = 1'b0;
         reverse_reg = 1'b0;
         errors      = 0;
      endfunction

      function int clamp_size(logic [CFG_W-1:0] v, int limit);
         if (v < 1) return 1;
         if (int'(v) > limit) return limit;
         return int'(v);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_NUM_COLUMNS:   columns_reg = data;
            CSR_NUM_ROWS:      rows_reg    = data;
            CSR_FLIP_ROWS:     flip_reg    = data[0];
            CSR_REVERSE_ORDER: reverse_reg = data[0];
            default: ;
         endcase
      endfunction

      // squares off the grid are silently skipped
      function void store_step(int x, int y, int cols, int rows, int step);
         if (x < 0 || y < 0 || x >= cols || y >= rows) return;
         step_table[x * rows + y] = step[ENTRY_W-1:0];
      endfunction

      function logic [VALUE_W-1:0] build_walk();
         int cols, rows, half, step, i, j, dx, dy;
         cols = clamp_size(columns_reg, DEF_MAX_COLUMNS);
         rows = clamp_size(rows_reg, DEF_MAX_ROWS);
         half = (cols * rows) / 2;
         step = 0;
         i = 0;
         j = 0;
         dx = 1;
         dy = -1;
         while (step < half) begin
            if (i >= 0 && j >= 0 && i < cols && j < rows) begin
               store_step(i, j, cols, rows, step);
               store_step(cols - i - 1, rows - j - 1, cols, rows, step);
            end
            step++;
            i += dx;
            j += dy;
            // bounce off the edge and turn round
            if (i < 0 || j < 0 || i >= cols || j >= rows) begin
               if (i >= cols) begin
                  i = cols - 1;
                  j += 2;
               end
               if (j >= rows) begin
                  j = rows - 1;
                  i += 2;
               end
               if (i < 0) i = 0;
               if (j < 0) j = 0;
               dx = -dx;
               dy = -dy;
            end
         end
         return VALUE_W'(cols * rows);
      endfunction

      function logic [VALUE_W-1:0] lookup_order(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         int cols, rows, xs, ys, stored, half;
         cols = clamp_size(columns_reg, DEF_MAX_COLUMNS);
         rows = clamp_size(rows_reg, DEF_MAX_ROWS);
         xs = int'(x);
         ys = int'(y);
         if (flip_reg) ys = rows - ys - 1;
         if (xs < 0 || ys < 0 || xs >= cols || ys >= rows) return '0;
         stored = int'(step_table[xs * rows + ys]);
         if (reverse_reg) return VALUE_W'(stored);
         half = (cols * rows) / 2;
         // countdown saturates at zero
         if (stored >= half) return '0;
         return VALUE_W'(half - stored - 1);
      endfunction

      function void note_request(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         if (op == OP_BUILD) expected_orders.push_back(build_walk());
         else expected_orders.push_back(lookup_order(x, y));
      endfunction

      function void check_order(logic [VALUE_W-1:0] got);
         logic [VALUE_W-1:0] want;
         if (expected_orders.size() == 0) begin
            $display("%0t: unexpected result, value %0d", $time, got);
            errors++;
            return;
         end
         want = expected_orders.pop_front();
         if (got !== want) begin
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;   // [5:0] square_x, [11:6] square_y, [15:12] zero
   logic                 req_tuser = 1'b0; // [0] operation
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;        // [12:0] value, [15:13] zero
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   scan_order_scoreboard sb;
   bit quiet = 1'b0;   // no idling on either side while set
   int sink_hold = 0;
   int sink_pick = 0;

   diagonal_snake_order_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout", $time);
      $display("status: fail");
      $finish;
   end

   // result sink: mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold  <= 0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
      end else begin
         sink_pick = $urandom_range(0, 99);
         if (sink_pick < 60) begin
            rsp_tready <= 1'b1;
            sink_hold  <= $urandom_range(0, 6);
         end else if (sink_pick < 92) begin
            rsp_tready <= 1'b0;
            sink_hold  <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            sink_hold  <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_order(rsp_tdata[VALUE_W-1:0]);
   end

   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, x, y);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_orders.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, data);
   endtask

   // single-bit registers get random upper bits, which the block must ignore
   task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows, logic flip,
                           logic rev);
      wait_idle();
      write_csr(CSR_NUM_COLUMNS, cols);
      write_csr(CSR_NUM_ROWS, rows);
      write_csr(CSR_FLIP_ROWS, {(CFG_W-1)'($urandom_range(0, 63)), flip});
      write_csr(CSR_REVERSE_ORDER, {(CFG_W-1)'($urandom_range(0, 63)), rev});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent, lookups, r, cols, rows;
      logic [CFG_W-1:0] pick_cols, pick_rows;
      logic [COORD_W-1:0] x, y;

      sb = new();
      sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset table and reset registers, then a plain 8x8 build
      send_item(OP_LOOKUP, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd63, 6'd63);
      send_item(OP_BUILD, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd7, 6'd7);
      send_item(OP_LOOKUP, 6'd3, 6'd4);
      send_item(OP_LOOKUP, 6'd63, 6'd0);

      // largest grid, flipped rows, stored step returned
      set_grid(7'd64, 7'd64, 1'b1, 1'b1);
      send_item(OP_BUILD, 6'd63, 6'd63);
      send_item(OP_LOOKUP, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd63, 6'd63);
      send_item(OP_LOOKUP, 6'd0, 6'd63);

      // shrink without rebuilding: stale entries, countdown saturates at zero
      set_grid(7'd4, 7'd4, 1'b0, 1'b0);
      send_item(OP_LOOKUP, 6'd1, 6'd1);
      send_item(OP_LOOKUP, 6'd3, 6'd2);

      // zero size saturates to one square
      set_grid(7'd0, 7'd0, 1'b0, 1'b0);
      send_item(OP_BUILD, 6'd21, 6'd42);
      send_item(OP_LOOKUP, 6'd0, 6'd0);

      // oversize saturates to the maximum
      set_grid(7'd127, 7'd127, 1'b0, 1'b1);
      send_item(OP_LOOKUP, 6'd5, 6'd9);

      // odd and tiny widths, where the walk leaves the grid
      set_grid(7'd5, 7'd3, 1'b1, 1'b0);
      send_item(OP_BUILD, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd4, 6'd2);
      send_item(OP_LOOKUP, 6'd2, 6'd1);
      set_grid(7'd1, 7'd7, 1'b0, 1'b1);
      send_item(OP_BUILD, 6'd0, 6'd0);
      send_item(OP_LOOKUP, 6'd0, 6'd6);
      send_item(OP_LOOKUP, 6'd1, 6'd0);
      sent = 22;

      while (sent < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            pick_cols = CFG_W'(2 * $urandom_range(1, 6));
            pick_rows = CFG_W'($urandom_range(1, 12));
         end else if (r < 78) begin
            pick_cols = CFG_W'($urandom_range(0, 7));
            pick_rows = CFG_W'($urandom_range(0, 9));
         end else if (r < 92) begin
            pick_cols = CFG_W'($urandom_range(13, 64));
            pick_rows = CFG_W'($urandom_range(1, 20));
         end else begin
            pick_cols = CFG_W'($urandom_range(60, 127));
            pick_rows = CFG_W'($urandom_range(60, 127));
         end
         set_grid(pick_cols, pick_rows, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         quiet = ($urandom_range(0, 3) == 0);
         cols = sb.clamp_size(pick_cols, DEF_MAX_COLUMNS);
         rows = sb.clamp_size(pick_rows, DEF_MAX_ROWS);

         // a phase without a build reads what earlier builds left behind
         if ($urandom_range(0, 3) != 0) begin
            send_item(OP_BUILD, COORD_W'($urandom), COORD_W'($urandom));
            sent++;
         end
         lookups = $urandom_range(4, 24);
         repeat (lookups) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
               x = COORD_W'($urandom_range(0, cols - 1));
               y = COORD_W'($urandom_range(0, rows - 1));
            end else begin
               x = COORD_W'($urandom_range(0, 63));
               y = COORD_W'($urandom_range(0, 63));
            end
            send_item((r < 3 && cols * rows <= 256) ? OP_BUILD : OP_LOOKUP, x, y);
            sent++;
         end
      end

      wait_idle();
      quiet = 1'b0;
      repeat (12) @(posedge clock);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/dsot_pkg.sv
src/dsot_table_mem.sv
src/dsot_datapath.sv
src/dsot_ctrl.sv
src/diagonal_snake_order_table_core.sv
test/tb.sv
